/* rtl/utf8_stream_decoder_macros.svh */
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define U8SD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8sd assertion failed");
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8sd assertion failed");
`else
`define U8SD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/u8sd_pkg.sv */
package u8sd_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned CpW      = 21;
   localparam int unsigned PendW    = 2;

   localparam logic [ByteW-1:0] LeadMultiBit = 8'b1000_0000;
   localparam logic [ByteW-1:0] LeadTwoBit   = 8'b0010_0000;
   localparam logic [ByteW-1:0] LeadThreeBit = 8'b0001_0000;
   localparam logic [ByteW-1:0] ContMask     = 8'b0011_1111;
   localparam logic [ByteW-1:0] TwoMask      = 8'b0001_1111;
   localparam logic [ByteW-1:0] ThreeMask    = 8'b0000_1111;
   localparam logic [ByteW-1:0] FourMask     = 8'b0000_0111;
   localparam logic [ByteW-1:0] AsciiMask    = 8'b0111_1111;

   typedef struct packed {
      logic [CpW-1:0] codepoint;
      logic           code_valid;
      logic           string_end;
   } result_type;

   typedef struct packed {
      logic [CpW-1:0]   partial_bits;
      logic [PendW-1:0] bytes_pending;
      logic             draining;
   } state_type;

   typedef struct packed {
      logic [ByteW-1:0] byte_in;
      logic             final_byte;
   } item_type;

endpackage

/* rtl/utf8_stream_decoder.sv */
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_byte_in[7:0], req_final_byte
// rsp       out        rsp_valid/rsp_stall  rsp_codepoint[20:0], rsp_code_valid,
//                                           rsp_string_end
// One byte per cycle while no held result stalls it: a byte is taken into the input
// register, is decoded against the sequence state and lands in the result register,
// which drives rsp_valid. Reset clears the valid bits and the sequence state.
// A held result only stalls bytes that would produce a result; other bytes
// still pass through and update the state.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder
   import u8sd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ByteW-1:0] req_byte_in,
   input  logic             req_final_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CpW-1:0]   rsp_codepoint,
   output logic             rsp_code_valid,
   output logic             rsp_string_end
);

   item_type   req_item, item;
   logic       item_vld, consume, emit, out_free;
   result_type result, rsp;
   state_type  state;

   assign req_item = '{byte_in: req_byte_in, final_byte: req_final_byte};
   // a byte leaves the input register unless its result has nowhere to go
   assign consume  = item_vld && (!emit || out_free);

   u8sd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .consume   (consume),
      .req_stall (req_stall),
      .item_vld  (item_vld),
      .item      (item)
   );

   u8sd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .consume (consume),
      .emit    (emit),
      .result  (result),
      .state   (state)
   );

   u8sd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (consume && emit),
      .result    (result),
      .rsp_stall (rsp_stall),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_codepoint  = rsp.codepoint;
   assign rsp_code_valid = rsp.code_valid;
   assign rsp_string_end = rsp.string_end;

   `U8SD_ASSERT_IMPLY(a_nocode_is_end, clock, reset, rsp_valid && !rsp_code_valid, rsp_string_end && (rsp_codepoint == '0))
   `U8SD_ASSERT_IMPLY(a_code_nonzero, clock, reset, rsp_valid && rsp_code_valid, rsp_codepoint != '0)
   `U8SD_ASSERT_IMPLY(a_drain_clean, clock, reset, state.draining, (state.bytes_pending == '0) && (state.partial_bits == '0))
   `U8SD_ASSERT_IMPLY(a_stall_held, clock, reset, req_stall, item_vld && emit && rsp_valid && rsp_stall)
   `U8SD_ASSERT_NEXT(a_held_rsp, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_codepoint))

endmodule

/* rtl/u8sd_in_reg.sv */
module u8sd_in_reg
   import u8sd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  item_type req_item,
   input  logic     consume,
   output logic     req_stall,
   output logic     item_vld,
   output item_type item
);

   logic     vld_ff, vld_in;
   item_type item_ff;

   assign req_stall = vld_ff && !consume;
   assign vld_in    = (req_valid && !req_stall) || (vld_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

/* rtl/u8sd_decode.sv */
module u8sd_decode
   import u8sd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       consume,
   output logic       emit,
   output result_type result,
   output state_type  state
);

   state_type        state_ff, state_in;
   logic [CpW-1:0]   shifted;
   logic [PendW-1:0] pend_dec;
   logic [ByteW-1:0] b;
   logic             last;

   assign b        = item.byte_in;
   assign last     = item.final_byte;
   assign shifted  = {state_ff.partial_bits[CpW-7:0], b[5:0]};
   assign pend_dec = state_ff.bytes_pending - PendW'(1);

   always_comb begin
      state_in = state_ff;
      emit     = 1'b0;
      result   = '0;
      if (state_ff.draining) begin
         if (last) begin
            state_in.draining = 1'b0;
         end
      end else if (b == '0) begin
         state_in = '{partial_bits: '0, bytes_pending: '0, draining: !last};
         emit     = 1'b1;
         result.string_end = 1'b1;
      end else if (state_ff.bytes_pending == '0) begin
         if ((b & LeadMultiBit) == '0) begin
            emit       = 1'b1;
            result     = '{codepoint: CpW'(b & AsciiMask), code_valid: 1'b1,
                           string_end: last};
         end else begin
            if ((b & LeadTwoBit) == '0) begin
               state_in.partial_bits  = CpW'(b & TwoMask);
               state_in.bytes_pending = PendW'(1);
            end else if ((b & LeadThreeBit) == '0) begin
               state_in.partial_bits  = CpW'(b & ThreeMask);
               state_in.bytes_pending = PendW'(2);
            end else begin
               state_in.partial_bits  = CpW'(b & FourMask);
               state_in.bytes_pending = PendW'(3);
            end
            // string ended inside the sequence
            if (last) begin
               state_in = '0;
               emit     = 1'b1;
               result.string_end = 1'b1;
            end
         end
      end else if (pend_dec == '0) begin
         state_in.partial_bits  = '0;
         state_in.bytes_pending = '0;
         emit = 1'b1;
         if (shifted == '0) begin
            state_in.draining = !last;
            result.string_end = 1'b1;
         end else begin
            result = '{codepoint: shifted, code_valid: 1'b1, string_end: last};
         end
      end else begin
         state_in.partial_bits  = shifted;
         state_in.bytes_pending = pend_dec;
         if (last) begin
            state_in = '0;
            emit     = 1'b1;
            result.string_end = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (consume) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

/* rtl/u8sd_rsp_reg.sv */
module u8sd_rsp_reg
   import u8sd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   input  logic       rsp_stall,
   output logic       out_free,
   output logic       rsp_valid,
   output result_type rsp
);

   logic       vld_ff, vld_in;
   result_type rsp_ff;

   assign out_free = !vld_ff || !rsp_stall;
   assign vld_in   = load || (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp       = rsp_ff;

endmodule
